@@ hdl/ray_box_face_intersect_macros.svh @@
// Assertion helpers for the checker of the ray/box block.
`ifndef RAY_BOX_FACE_INTERSECT_MACROS_SVH
`define RAY_BOX_FACE_INTERSECT_MACROS_SVH

// Plain property, sampled on the rising edge, off while reset is high.
`define RBFI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Signal must hold its value in the cycle after the condition.
`define RBFI_ASSERT_STABLE(lbl, clk, rst, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

@@ hdl/rbfi_pkg.sv @@
package rbfi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int FIELD_WIDTH     = 32;
  localparam int DIST_WIDTH      = 31;
  localparam int FACE_WIDTH      = 3;
  // width of the t slice taken by each multiply step
  localparam int MUL_CHUNK       = 16;

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

  localparam logic [FACE_WIDTH-1:0] FACE_NONE   = 3'd0;
  localparam logic [FACE_WIDTH-1:0] FACE_INSIDE = 3'd1;
  localparam logic [FACE_WIDTH-1:0] FACE_NEG_X  = 3'd2;
  localparam logic [FACE_WIDTH-1:0] FACE_POS_X  = 3'd3;
  localparam logic [FACE_WIDTH-1:0] FACE_NEG_Y  = 3'd4;
  localparam logic [FACE_WIDTH-1:0] FACE_POS_Y  = 3'd5;
  localparam logic [FACE_WIDTH-1:0] FACE_NEG_Z  = 3'd6;
  localparam logic [FACE_WIDTH-1:0] FACE_POS_Z  = 3'd7;

endpackage

@@ hdl/rbfi_query_if.sv @@
interface rbfi_query_if;
  logic valid;
  logic ready;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] origin_x;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] origin_y;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] origin_z;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] dir_x;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] dir_y;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] dir_z;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] min_x;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] min_y;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] min_z;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] max_x;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] max_y;
  logic [rbfi_pkg::FIELD_WIDTH-1:0] max_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           min_x, min_y, min_z, max_x, max_y, max_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           min_x, min_y, min_z, max_x, max_y, max_z,
    output ready
  );
endinterface

@@ hdl/rbfi_result_if.sv @@
interface rbfi_result_if;
  logic valid;
  logic ready;
  logic hit;
  logic [rbfi_pkg::DIST_WIDTH-1:0] distance;
  logic [rbfi_pkg::FACE_WIDTH-1:0] face;

  modport source (output valid, hit, distance, face, input ready);
  modport sink (input valid, hit, distance, face, output ready);
endinterface

@@ hdl/rbfi_delay.sv @@
module rbfi_delay #(
  parameter int DW    = 8,
  parameter int DEPTH = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_data,
  output logic          out_valid,
  output logic [DW-1:0] out_data
);

  logic [DEPTH-1:0] vld;
  logic [DW-1:0]    dat [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        dat[i] <= dat[i-1];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = dat[DEPTH-1];

endmodule

@@ hdl/rbfi_div.sv @@
// Restoring divider, one quotient bit per stage.
module rbfi_div #(
  parameter int W  = 32,
  parameter int QW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] dividend,
  input  logic [W-1:0]  divisor,
  output logic [QW-1:0] quotient
);

  logic [W-1:0]  s_rem [QW+1];
  logic [QW-1:0] s_dvd [QW+1];
  logic [QW-1:0] s_quo [QW+1];
  logic [W-1:0]  s_den [QW+1];

  assign s_rem[0] = '0;
  assign s_dvd[0] = dividend;
  assign s_quo[0] = '0;
  assign s_den[0] = divisor;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [W:0]    trial;
    logic          ge;
    logic [W:0]    diff;
    logic [W-1:0]  rem;
    logic [QW-1:0] dvd;
    logic [QW-1:0] quo;
    logic [W-1:0]  den;

    assign trial = {s_rem[k], s_dvd[k][QW-1]};
    assign ge    = trial >= {1'b0, s_den[k]};
    assign diff  = trial - {1'b0, s_den[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem <= ge ? diff[W-1:0] : trial[W-1:0];
        dvd <= {s_dvd[k][QW-2:0], 1'b0};
        quo <= {s_quo[k][QW-2:0], ge};
        den <= s_den[k];
      end
    end

    assign s_rem[k+1] = rem;
    assign s_dvd[k+1] = dvd;
    assign s_quo[k+1] = quo;
    assign s_den[k+1] = den;
  end

  assign quotient = s_quo[QW];

endmodule

@@ hdl/rbfi_mul.sv @@
// Unsigned W x QW multiply, one MUL_CHUNK slice of t per stage.
module rbfi_mul #(
  parameter int W  = 32,
  parameter int QW = 48
) (
  input  logic            clk,
  input  logic            en,
  input  logic [W-1:0]    mag,
  input  logic [QW-1:0]   t,
  output logic [W+QW-1:0] prod
);

  localparam int CW  = rbfi_pkg::MUL_CHUNK;
  localparam int NCH = (QW + CW - 1) / CW;
  localparam int TW  = NCH * CW;
  localparam int AW  = W + QW;

  logic [AW-1:0] s_acc [NCH+1];
  logic [W-1:0]  s_mag [NCH+1];
  logic [TW-1:0] s_t   [NCH+1];

  assign s_acc[0] = '0;
  assign s_mag[0] = mag;
  assign s_t[0]   = TW'(t);

  for (genvar k = 0; k < NCH; k++) begin : g_step
    logic [W+CW-1:0] part;
    logic [AW-1:0]   acc;
    logic [W-1:0]    mag_r;
    logic [TW-1:0]   t_r;

    assign part = s_mag[k] * s_t[k][k*CW +: CW];

    always_ff @(posedge clk) begin
      if (en) begin
        acc   <= s_acc[k] + (AW'(part) << (k * CW));
        mag_r <= s_mag[k];
        t_r   <= s_t[k];
      end
    end

    assign s_acc[k+1] = acc;
    assign s_mag[k+1] = mag_r;
    assign s_t[k+1]   = t_r;
  end

  assign prod = s_acc[NCH];

endmodule

@@ hdl/ray_box_face_intersect.sv @@
// Pipeline: stage A, the one-bit-per-stage divider, the sliced multiply, the bounds
//   register and the output register.
// Throughput: one word per cycle; a stall at the result port freezes the whole pipe.
// Reset (synchronous, active high) clears the valid bits only; the data registers are not reset.
module ray_box_face_intersect #(
  parameter int COORD_WIDTH = rbfi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbfi_pkg::FRAC_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  rbfi_query_if.sink    query,
  rbfi_result_if.source result
);

  localparam int W   = COORD_WIDTH;
  localparam int QW  = W + FRAC_BITS;
  localparam int CW  = rbfi_pkg::MUL_CHUNK;
  localparam int NCH = (QW + CW - 1) / CW;
  localparam int AW  = W + QW;
  localparam int SPW = 2 * W + 2;
  localparam int DW  = rbfi_pkg::DIST_WIDTH;
  localparam int MW  = (QW > DW) ? QW : DW;

  typedef struct packed {
    logic [2:0][W-1:0] org;
    logic [2:0][W-1:0] dir;
    logic [2:0][W-1:0] lo;
    logic [2:0][W-1:0] hi;
    logic [2:0]        test;
    logic [2:0]        is_max;
    logic              enclosed;
  } side_t;

  typedef struct packed {
    side_t              s;
    logic [2:0][QW-1:0] t;
  } side2_t;

  logic en;
  logic out_valid;
  logic out_hit;
  logic [DW-1:0] out_distance;
  logic [rbfi_pkg::FACE_WIDTH-1:0] out_face;

  assign en          = !out_valid || result.ready;
  assign query.ready = en;

  // ---- stage A: unpack, origin-in-box test, face pick and divider operands
  logic [2:0][rbfi_pkg::FIELD_WIDTH-1:0] f_org, f_dir, f_lo, f_hi;
  side_t      c_side;
  logic [2:0][W-1:0] c_num, c_den;

  assign f_org = {query.origin_z, query.origin_y, query.origin_x};
  assign f_dir = {query.dir_z, query.dir_y, query.dir_x};
  assign f_lo  = {query.min_z, query.min_y, query.min_x};
  assign f_hi  = {query.max_z, query.max_y, query.max_x};

  always_comb begin
    c_side.enclosed = 1'b1;
    for (int k = 0; k < 3; k++) begin
      c_side.org[k] = W'(64'(f_org[k]));
      c_side.dir[k] = W'(64'(f_dir[k]));
      c_side.lo[k]  = W'(64'(f_lo[k]));
      c_side.hi[k]  = W'(64'(f_hi[k]));
    end
    for (int k = 0; k < 3; k++) begin
      if (!($signed(c_side.org[k]) > $signed(c_side.lo[k]) &&
            $signed(c_side.org[k]) < $signed(c_side.hi[k]))) begin
        c_side.enclosed = 1'b0;
      end
      // direction sign decides which face of the axis can be met
      c_side.is_max[k] = c_side.dir[k][W-1];
      if (c_side.dir[k][W-1]) begin
        c_side.test[k] = $signed(c_side.org[k]) >= $signed(c_side.hi[k]);
        c_num[k] = c_side.org[k] - c_side.hi[k];
        c_den[k] = -c_side.dir[k];
      end else begin
        c_side.test[k] = (c_side.dir[k] != '0) &&
                         ($signed(c_side.org[k]) <= $signed(c_side.lo[k]));
        c_num[k] = c_side.lo[k] - c_side.org[k];
        c_den[k] = c_side.dir[k];
      end
    end
  end

  side_t             sa;
  logic [2:0][W-1:0] num_a, den_a;
  logic              va;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa    <= c_side;
      num_a <= c_num;
      den_a <= c_den;
    end
  end

  // ---- divider: t = (|plane - origin| << FRAC_BITS) / |dir|
  logic [2:0][QW-1:0] quo;

  for (genvar ax = 0; ax < 3; ax++) begin : g_div
    rbfi_div #(.W(W), .QW(QW)) u_div (
      .clk      (clk),
      .en       (en),
      .dividend ({num_a[ax], {FRAC_BITS{1'b0}}}),
      .divisor  (den_a[ax]),
      .quotient (quo[ax])
    );
  end

  side_t sb;
  logic  vb;

  rbfi_delay #(.DW($bits(side_t)), .DEPTH(QW)) u_dly_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (va),
    .in_data   (sa),
    .out_valid (vb),
    .out_data  (sb)
  );

  // ---- multiply: |dir_a| * t for the two other axes of each face
  logic [2:0][1:0][AW-1:0] prod;

  for (genvar ax = 0; ax < 3; ax++) begin : g_face
    for (genvar j = 0; j < 2; j++) begin : g_other
      localparam int A = (ax + j + 1) % 3;
      logic [W-1:0] mag;
      assign mag = sb.dir[A][W-1] ? -sb.dir[A] : sb.dir[A];
      rbfi_mul #(.W(W), .QW(QW)) u_mul (
        .clk  (clk),
        .en   (en),
        .mag  (mag),
        .t    (quo[ax]),
        .prod (prod[ax][j])
      );
    end
  end

  side2_t sc;
  logic   vc;

  rbfi_delay #(.DW($bits(side2_t)), .DEPTH(NCH)) u_dly_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb),
    .in_data   ({sb, quo}),
    .out_valid (vc),
    .out_data  (sc)
  );

  // ---- bounds: p = origin_a + floor(dir_a * t / 2^F), inclusive box check
  logic [2:0][1:0] in_bounds;

  for (genvar ax = 0; ax < 3; ax++) begin : g_bnd
    for (genvar j = 0; j < 2; j++) begin : g_other
      localparam int A = (ax + j + 1) % 3;
      logic [SPW-1:0]        off_mag;
      logic signed [SPW-1:0] off, p, lo_e, hi_e;
      logic                  frac_nz;

      // floor of a negative product rounds the magnitude up
      assign frac_nz = |prod[ax][j][FRAC_BITS-1:0];
      assign off_mag = SPW'(prod[ax][j][AW-1:FRAC_BITS]) + SPW'(frac_nz && sc.s.dir[A][W-1]);
      assign off     = sc.s.dir[A][W-1] ? -$signed(off_mag) : $signed(off_mag);
      assign p       = SPW'($signed(sc.s.org[A])) + off;
      assign lo_e    = SPW'($signed(sc.s.lo[A]));
      assign hi_e    = SPW'($signed(sc.s.hi[A]));
      assign in_bounds[ax][j] = !(p < lo_e) && !(hi_e < p);
    end
  end

  logic [2:0]         cand_d;
  logic [2:0][QW-1:0] t_d;
  logic [2:0]         max_d;
  logic               enclosed_d;
  logic               vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cand_d[k] <= sc.s.test[k] && in_bounds[k][0] && in_bounds[k][1];
      end
      t_d        <= sc.t;
      max_d      <= sc.s.is_max;
      enclosed_d <= sc.s.enclosed;
    end
  end

  // ---- select nearest face, earlier axis wins a tie; an origin inside the box gives FACE_INSIDE
  logic                            sel_found;
  logic [QW-1:0]                   sel_t;
  logic [1:0]                      sel_ax;
  logic                            sel_max;
  logic                            sel_hit;
  logic [DW-1:0]                   sel_dist;
  logic [rbfi_pkg::FACE_WIDTH-1:0] sel_face;

  always_comb begin
    sel_found = 1'b0;
    sel_t     = '0;
    sel_ax    = 2'd0;
    sel_max   = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (cand_d[k] && (!sel_found || t_d[k] < sel_t)) begin
        sel_found = 1'b1;
        sel_t     = t_d[k];
        sel_ax    = 2'(k);
        sel_max   = max_d[k];
      end
    end
    if (enclosed_d) begin
      sel_hit  = 1'b1;
      sel_dist = '0;
      sel_face = rbfi_pkg::FACE_INSIDE;
    end else if (sel_found) begin
      sel_hit  = 1'b1;
      sel_dist = (MW'(sel_t) > MW'(rbfi_pkg::DIST_MAX)) ? rbfi_pkg::DIST_MAX : DW'(sel_t);
      unique case (sel_ax)
        2'd0:    sel_face = sel_max ? rbfi_pkg::FACE_POS_X : rbfi_pkg::FACE_NEG_X;
        2'd1:    sel_face = sel_max ? rbfi_pkg::FACE_POS_Y : rbfi_pkg::FACE_NEG_Y;
        default: sel_face = sel_max ? rbfi_pkg::FACE_POS_Z : rbfi_pkg::FACE_NEG_Z;
      endcase
    end else begin
      sel_hit  = 1'b0;
      sel_dist = '0;
      sel_face = rbfi_pkg::FACE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit      <= sel_hit;
      out_distance <= sel_dist;
      out_face     <= sel_face;
    end
  end

  assign result.valid    = out_valid;
  assign result.hit      = out_hit;
  assign result.distance = out_distance;
  assign result.face     = out_face;

endmodule

@@ hdl/rbfi_checker.sv @@
`include "ray_box_face_intersect_macros.svh"

module rbfi_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            hit,
  input logic [rbfi_pkg::DIST_WIDTH-1:0] distance,
  input logic [rbfi_pkg::FACE_WIDTH-1:0] face
);

  `RBFI_ASSERT_STABLE(a_out_hold, clk, rst, out_valid && !out_ready, {out_valid, hit, distance, face}, "stalled result word changed")
  `RBFI_ASSERT(a_ready_free, clk, rst, !out_valid |-> in_ready, "input not ready with empty output")
  `RBFI_ASSERT(a_miss_clean, clk, rst, out_valid && !hit |-> face == rbfi_pkg::FACE_NONE && distance == '0, "miss word not cleared")
  `RBFI_ASSERT(a_hit_face, clk, rst, out_valid && hit |-> face != rbfi_pkg::FACE_NONE, "hit without a face")
  `RBFI_ASSERT(a_inside_zero, clk, rst, out_valid && face == rbfi_pkg::FACE_INSIDE |-> hit && distance == '0, "inside word with nonzero distance")

endmodule

bind ray_box_face_intersect rbfi_checker u_rbfi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (query.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .hit       (result.hit),
  .distance  (result.distance),
  .face      (result.face)
);

@@ tb/sv/tb_ray_box_face_intersect.sv @@
`timescale 1ns / 1ps

module tb_ray_box_face_intersect;

  localparam int NUM_RANDOM  = 1250;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 60;

  // v: origin xyz, dir xyz, min xyz, max xyz
  typedef struct packed {
    logic              wait_drain;
    logic [11:0][31:0] v;
  } ray_query_t;

  typedef struct packed {
    logic                            hit;
    logic [rbfi_pkg::DIST_WIDTH-1:0] distance;
    logic [rbfi_pkg::FACE_WIDTH-1:0] face;
  } ray_hit_t;

  logic clk;
  logic rst;

  rbfi_query_if  qif ();
  rbfi_result_if rif ();

  ray_box_face_intersect i_dut (
    .clk    (clk),
    .rst    (rst),
    .query  (qif),
    .result (rif)
  );

  ray_query_t query_fifo[$];
  ray_hit_t   hit_fifo[$];
  int         n_sent;
  int         n_checked;
  int         n_hits;
  int         n_mismatch;
  int         idle_cycles;
  int         hold_cnt;
  bit         hold_done;
  bit         gen_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    qif.valid = 1'b0;
    {qif.origin_x, qif.origin_y, qif.origin_z} = '0;
    {qif.dir_x, qif.dir_y, qif.dir_z} = '0;
    {qif.min_x, qif.min_y, qif.min_z} = '0;
    {qif.max_x, qif.max_y, qif.max_z} = '0;
    rif.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic ray_hit_t trace_box(ray_query_t q);
    longint                          org[3], dr[3], lo[3], hi[3];
    logic signed [127:0]             t, p, best;
    logic [127:0]                    num, den;
    bit                              found, inb;
    int                              ax, a;
    logic [rbfi_pkg::FACE_WIDTH-1:0] best_face;
    ray_hit_t                        r;
    found = 0;
    best = '0;
    best_face = rbfi_pkg::FACE_NONE;
    for (int k = 0; k < 3; k++) begin
      org[k] = longint'($signed(q.v[k]));
      dr[k]  = longint'($signed(q.v[3 + k]));
      lo[k]  = longint'($signed(q.v[6 + k]));
      hi[k]  = longint'($signed(q.v[9 + k]));
    end
    if (org[0] > lo[0] && org[1] > lo[1] && org[2] > lo[2] &&
        org[0] < hi[0] && org[1] < hi[1] && org[2] < hi[2]) begin
      r.hit = 1'b1;
      r.distance = '0;
      r.face = rbfi_pkg::FACE_INSIDE;
      return r;
    end
    for (int f = 0; f < 6; f++) begin
      ax = f / 2;
      if (f % 2 == 1) begin
        if (!(org[ax] >= hi[ax] && dr[ax] < 0)) continue;
        num = 128'(org[ax] - hi[ax]);
        den = 128'(-dr[ax]);
      end else begin
        if (!(org[ax] <= lo[ax] && dr[ax] > 0)) continue;
        num = 128'(lo[ax] - org[ax]);
        den = 128'(dr[ax]);
      end
      t = $signed((num << rbfi_pkg::FRAC_BITS_DEF) / den);
      inb = 1;
      for (int j = 1; j <= 2; j++) begin
        a = (ax + j) % 3;
        p = ($signed(128'(dr[a])) * t) >>> rbfi_pkg::FRAC_BITS_DEF;
        p = p + $signed(128'(org[a]));
        if (p < $signed(128'(lo[a])) || p > $signed(128'(hi[a]))) inb = 0;
      end
      if (inb && (!found || t < best)) begin
        found = 1;
        best = t;
        best_face = rbfi_pkg::FACE_NEG_X + rbfi_pkg::FACE_WIDTH'(f);
      end
    end
    r.hit = found;
    r.face = best_face;
    if (!found) r.distance = '0;
    else if (best > $signed(128'(rbfi_pkg::DIST_MAX))) r.distance = rbfi_pkg::DIST_MAX;
    else r.distance = best[rbfi_pkg::DIST_WIDTH-1:0];
    return r;
  endfunction

  function automatic ray_query_t mk(longint o0, o1, o2, d0, d1, d2,
                                    longint l0, l1, l2, h0, h1, h2);
    ray_query_t q;
    q.wait_drain = 1'b0;
    q.v = {32'(h2), 32'(h1), 32'(h0), 32'(l2), 32'(l1), 32'(l0),
           32'(d2), 32'(d1), 32'(d0), 32'(o2), 32'(o1), 32'(o0)};
    return q;
  endfunction

  // ray aimed at a point of a random box, with occasional zeroed axes and plane hits
  function automatic ray_query_t aimed_ray();
    ray_query_t q;
    longint     c, s, tg, o;
    int         sh;
    q.wait_drain = 1'b0;
    sh = $urandom_range(0, 5);
    for (int k = 0; k < 3; k++) begin
      c  = longint'($signed(32'($urandom))) >>> 9;
      s  = $urandom_range(1, 1 << 20);
      tg = c - s + longint'($urandom_range(0, 2 * s));
      o  = tg + (longint'($signed(32'($urandom))) >>> $urandom_range(7, 12));
      if ($urandom_range(0, 15) == 0) o = c - s;
      if ($urandom_range(0, 15) == 0) o = c + s;
      q.v[k]     = 32'(o);
      q.v[3 + k] = ($urandom_range(0, 11) == 0) ? 32'd0 : 32'((tg - o) >>> sh);
      q.v[6 + k] = 32'(c - s);
      q.v[9 + k] = 32'(c + s);
    end
    return q;
  endfunction

  initial begin
    ray_query_t q;
    localparam longint ONE = 65536;
    localparam longint MX = 32'h7fffffff;
    localparam longint MN = -64'sd2147483648;
    // inside, each face struck, miss, zero direction, on-plane, inverted, saturation
    query_fifo.push_back(mk(0, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(-5*ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(5*ONE, 0, 0, -ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(0, -5*ONE, 0, 0, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(0, 5*ONE, 0, 0, -ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(0, 0, -5*ONE, 0, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(0, 0, 5*ONE, 0, 0, -ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(-5*ONE, 5*ONE, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(-5*ONE, 0, 0, -ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(-5*ONE, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(-ONE, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(-ONE, -ONE, -ONE, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(-5*ONE, 0, 0, ONE, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE));
    query_fifo.push_back(mk(-5*ONE, -5*ONE, 0, ONE, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    query_fifo.push_back(mk(MN, 0, 0, 1, 0, 0, MX - 1, MN, MN, MX, MX, MX));
    query_fifo.push_back(mk(MX, 0, 0, -1, 0, 0, MN, MN, MN, MN + 1, MX, MX));
    query_fifo.push_back(mk(MN, MN, MN, MX, MX, MX, MX, MX, MX, MX, MX, MX));
    query_fifo.push_back(mk(MX, MX, MX, MN, MN, MN, MN, MN, MN, MN, MN, MN));
    query_fifo.push_back(mk(MN, MN, MN, MN, MN, MN, MN, MN, MN, MX, MX, MX));
    query_fifo.push_back(mk(MX, MX, MX, MX, MX, MX, MN, MN, MN, MX, MX, MX));
    query_fifo.push_back(mk(-1, 0, 0, MX, 1, -1, MN, MN, MN, MX, MX, MX));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        for (int k = 0; k < 12; k++) q.v[k] = $urandom;
        q.wait_drain = 1'b0;
      end else begin
        q = aimed_ray();
      end
      if (i == 300 || i == 900) q.wait_drain = 1'b1;
      query_fifo.push_back(q);
    end
    gen_done = 1;
  end

  function automatic int phase_of(int n);
    return (n < 420) ? 0 : (n < 840) ? 1 : 2;
  endfunction

  // driver
  always @(posedge clk) begin
    bit send_idle;
    if (rst) begin
      qif.valid <= 1'b0;
      n_sent <= 0;
    end else begin
      if (qif.valid && qif.ready) begin
        hit_fifo.push_back(trace_box({1'b0, qif.max_z, qif.max_y, qif.max_x,
                                      qif.min_z, qif.min_y, qif.min_x,
                                      qif.dir_z, qif.dir_y, qif.dir_x,
                                      qif.origin_z, qif.origin_y, qif.origin_x}));
        n_sent <= n_sent + 1;
      end
      if (!qif.valid || qif.ready) begin
        case (phase_of(n_sent))
          0: send_idle = $urandom_range(0, 99) < 21;
          1: send_idle = $urandom_range(0, 99) < 88;
          default: send_idle = 0;
        endcase
        if (query_fifo.size() > 0 && !send_idle &&
            !(query_fifo[0].wait_drain &&
              (hit_fifo.size() > 0 || (qif.valid && qif.ready)))) begin
          qif.valid    <= 1'b1;
          qif.origin_x <= query_fifo[0].v[0];
          qif.origin_y <= query_fifo[0].v[1];
          qif.origin_z <= query_fifo[0].v[2];
          qif.dir_x    <= query_fifo[0].v[3];
          qif.dir_y    <= query_fifo[0].v[4];
          qif.dir_z    <= query_fifo[0].v[5];
          qif.min_x    <= query_fifo[0].v[6];
          qif.min_y    <= query_fifo[0].v[7];
          qif.min_z    <= query_fifo[0].v[8];
          qif.max_x    <= query_fifo[0].v[9];
          qif.max_y    <= query_fifo[0].v[10];
          qif.max_z    <= query_fifo[0].v[11];
          void'(query_fifo.pop_front());
        end else begin
          qif.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    ray_hit_t exp_r;
    bit       recv_idle;
    if (rst) begin
      rif.ready <= 1'b0;
      n_checked <= 0;
      n_hits <= 0;
      n_mismatch <= 0;
      hold_cnt <= 0;
      hold_done <= 0;
    end else begin
      if (rif.valid && rif.ready) begin
        if (hit_fifo.size() == 0) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10) $display("unexpected result word: hit=%0b dist=%0h face=%0d",
                                        rif.hit, rif.distance, rif.face);
        end else begin
          exp_r = hit_fifo.pop_front();
          if (exp_r.hit !== rif.hit || exp_r.distance !== rif.distance ||
              exp_r.face !== rif.face) begin
            n_mismatch <= n_mismatch + 1;
            if (n_mismatch < 10)
              $display({"mismatch #%0d: exp hit=%0b dist=%0h face=%0d, ",
                        "got hit=%0b dist=%0h face=%0d"},
                       n_checked, exp_r.hit, exp_r.distance, exp_r.face,
                       rif.hit, rif.distance, rif.face);
          end
          if (exp_r.hit) n_hits <= n_hits + 1;
        end
        n_checked <= n_checked + 1;
      end
      // one long hold-off so the pipe fills and backs up the query port
      if (!hold_done && n_checked >= 150 && hold_cnt < 400) begin
        hold_cnt <= hold_cnt + 1;
        rif.ready <= 1'b0;
        if (hold_cnt == 399) hold_done <= 1;
      end else begin
        case (phase_of(n_sent))
          0: recv_idle = $urandom_range(0, 99) < 88;
          1: recv_idle = $urandom_range(0, 99) < 21;
          default: recv_idle = 0;
        endcase
        rif.ready <= !recv_idle;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (qif.valid && qif.ready) || (rif.valid && rif.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("ray_box_face_intersect regression: fail");
        $finish;
      end
    end
  end

  initial begin
    wait (gen_done && !rst);
    wait (query_fifo.size() == 0 && !qif.valid && hit_fifo.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("queries sent %0d, results checked %0d (%0d hits), mismatches %0d",
             n_sent, n_checked, n_hits, n_mismatch);
    $display("covered inside, all six faces, misses, zero axes, on-plane, inverted, saturation");
    if (n_mismatch == 0 && hit_fifo.size() == 0) begin
      $display("ray_box_face_intersect regression: pass");
    end else begin
      $display("ray_box_face_intersect regression: fail");
    end
    $finish;
  end

endmodule
